[rtl/cau_pkg.sv]
// shared types and constants for the complex arithmetic unit
// no dependencies
package cau_pkg;

  localparam int DataWidthDef = 32;
  localparam int FracBitsDef  = 16;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  // control that travels with each word down the pipeline
  typedef struct packed {
    logic valid;
    logic div;
    logic dz;
    logic neg_re;
    logic neg_im;
  } ctl_t;

endpackage

[rtl/cau_front.sv]
// front end: products, sums and sign/magnitude split in three stages
// depends on cau_pkg
module cau_front #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  cau_pkg::op_t                         op,
  input  logic signed [DATA_WIDTH-1:0]         a_re,
  input  logic signed [DATA_WIDTH-1:0]         a_im,
  input  logic signed [DATA_WIDTH-1:0]         b_re,
  input  logic signed [DATA_WIDTH-1:0]         b_im,
  output cau_pkg::ctl_t                        ctl,
  output logic [2*DATA_WIDTH:0]                den_unused_guard,
  output logic [2*DATA_WIDTH+FRAC_BITS:0]      mag_re,
  output logic [2*DATA_WIDTH+FRAC_BITS:0]      mag_im,
  output logic [2*DATA_WIDTH-1:0]              den
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int W2 = 2 * W;
  localparam int NS = 2 * W + 1;
  localparam int NW = 2 * W + 1 + FRAC_BITS;

  // stage 1
  logic                 v1;
  op_t                  op1;
  logic signed [W2-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
  logic signed [W:0]    sum_re, sum_im;
  // stage 2
  logic                 v2;
  op_t                  op2;
  logic signed [NS-1:0] s_re, s_im;
  logic [W2-1:0]        den2;
  // stage 3 outputs are the module outputs

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1  <= op;
      p_rr <= W2'(a_re) * W2'(b_re);
      p_ii <= W2'(a_im) * W2'(b_im);
      p_ri <= W2'(a_re) * W2'(b_im);
      p_ir <= W2'(a_im) * W2'(b_re);
      p_bb <= W2'(b_re) * W2'(b_re);
      p_cc <= W2'(b_im) * W2'(b_im);
      if (op == OP_SUB) begin
        sum_re <= (W+1)'(a_re) - (W+1)'(b_re);
        sum_im <= (W+1)'(a_im) - (W+1)'(b_im);
      end else begin
        sum_re <= (W+1)'(a_re) + (W+1)'(b_re);
        sum_im <= (W+1)'(a_im) + (W+1)'(b_im);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2  <= op1;
      den2 <= W2'($unsigned(p_bb) + $unsigned(p_cc));
      case (op1)
        OP_MUL: begin
          s_re <= NS'(p_rr) - NS'(p_ii);
          s_im <= NS'(p_ri) + NS'(p_ir);
        end
        OP_DIV: begin
          s_re <= NS'(p_rr) + NS'(p_ii);
          s_im <= NS'(p_ir) - NS'(p_ri);
        end
        default: begin
          s_re <= NS'(sum_re);
          s_im <= NS'(sum_im);
        end
      endcase
    end
  end

  logic [NS-1:0] abs_re, abs_im;
  assign abs_re = s_re[NS-1] ? NS'(-s_re) : NS'(s_re);
  assign abs_im = s_im[NS-1] ? NS'(-s_im) : NS'(s_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= v2;
    end
    if (en) begin
      ctl.div    <= (op2 == OP_DIV);
      ctl.dz     <= (op2 == OP_DIV) && (den2 == '0);
      ctl.neg_re <= s_re[NS-1];
      ctl.neg_im <= s_im[NS-1];
      den        <= den2;
      case (op2)
        OP_MUL: begin
          // truncation toward zero: scale the magnitude
          mag_re <= NW'(abs_re >> FRAC_BITS);
          mag_im <= NW'(abs_im >> FRAC_BITS);
        end
        OP_DIV: begin
          mag_re <= NW'(abs_re) << FRAC_BITS;
          mag_im <= NW'(abs_im) << FRAC_BITS;
        end
        default: begin
          mag_re <= NW'(abs_re);
          mag_im <= NW'(abs_im);
        end
      endcase
    end
  end

  assign den_unused_guard = {1'b0, den};

endmodule

[rtl/cau_div_step.sv]
// one registered restoring-division step for both result parts
// depends on cau_pkg
module cau_div_step #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  cau_pkg::ctl_t                   ctl_in,
  input  logic [2*DATA_WIDTH-1:0]         den_in,
  input  logic [2*DATA_WIDTH+FRAC_BITS:0] nq_re_in,
  input  logic [2*DATA_WIDTH+FRAC_BITS:0] nq_im_in,
  input  logic [2*DATA_WIDTH-1:0]         rem_re_in,
  input  logic [2*DATA_WIDTH-1:0]         rem_im_in,
  output cau_pkg::ctl_t                   ctl_out,
  output logic [2*DATA_WIDTH-1:0]         den_out,
  output logic [2*DATA_WIDTH+FRAC_BITS:0] nq_re_out,
  output logic [2*DATA_WIDTH+FRAC_BITS:0] nq_im_out,
  output logic [2*DATA_WIDTH-1:0]         rem_re_out,
  output logic [2*DATA_WIDTH-1:0]         rem_im_out
);
  import cau_pkg::*;

  localparam int W2 = 2 * DATA_WIDTH;
  localparam int NW = 2 * DATA_WIDTH + 1 + FRAC_BITS;

  // numerator bits shift out the top while quotient bits shift in below
  logic [W2:0] t_re, t_im, d_ext;
  logic        ge_re, ge_im;

  assign d_ext = {1'b0, den_in};
  assign t_re  = {rem_re_in, nq_re_in[NW-1]};
  assign t_im  = {rem_im_in, nq_im_in[NW-1]};
  assign ge_re = (t_re >= d_ext);
  assign ge_im = (t_im >= d_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.div    <= ctl_in.div;
      ctl_out.dz     <= ctl_in.dz;
      ctl_out.neg_re <= ctl_in.neg_re;
      ctl_out.neg_im <= ctl_in.neg_im;
      den_out        <= den_in;
      if (ctl_in.div) begin
        nq_re_out  <= {nq_re_in[NW-2:0], ge_re};
        nq_im_out  <= {nq_im_in[NW-2:0], ge_im};
        rem_re_out <= ge_re ? W2'(t_re - d_ext) : W2'(t_re);
        rem_im_out <= ge_im ? W2'(t_im - d_ext) : W2'(t_im);
      end else begin
        nq_re_out  <= nq_re_in;
        nq_im_out  <= nq_im_in;
        rem_re_out <= rem_re_in;
        rem_im_out <= rem_im_in;
      end
    end
  end

endmodule

[rtl/cau_back.sv]
// output stage: sign restore, saturation, status, output register
// depends on cau_pkg
module cau_back #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  cau_pkg::ctl_t                   ctl,
  input  logic [2*DATA_WIDTH+FRAC_BITS:0] mag_re,
  input  logic [2*DATA_WIDTH+FRAC_BITS:0] mag_im,
  output logic                            out_valid,
  output logic [DATA_WIDTH-1:0]           res_re,
  output logic [DATA_WIDTH-1:0]           res_im,
  output cau_pkg::status_t                status
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int NW = 2 * DATA_WIDTH + 1 + FRAC_BITS;

  logic [W-1:0] sat_re, sat_im;
  logic         clip_re, clip_im;

  function automatic logic clips(input logic neg, input logic [NW-1:0] mag);
    if (neg) begin
      clips = (|mag[NW-1:W]) || (mag[W-1] && (|mag[W-2:0]));
    end else begin
      clips = |mag[NW-1:W-1];
    end
  endfunction

  function automatic logic [W-1:0] clamp(input logic neg, input logic clip,
                                         input logic [NW-1:0] mag);
    if (clip) begin
      clamp = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      clamp = neg ? W'(-mag[W-1:0]) : mag[W-1:0];
    end
  endfunction

  assign clip_re = clips(ctl.neg_re, mag_re);
  assign clip_im = clips(ctl.neg_im, mag_im);
  assign sat_re  = clamp(ctl.neg_re, clip_re, mag_re);
  assign sat_im  = clamp(ctl.neg_im, clip_im, mag_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl.dz) begin
        res_re <= '0;
        res_im <= '0;
        status <= ST_DZ;
      end else begin
        res_re <= sat_re;
        res_im <= sat_im;
        status <= (clip_re || clip_im) ? ST_SAT : ST_OK;
      end
    end
  end

endmodule

[rtl/complex_arithmetic_unit.sv]
// complex add/sub/mul/div on signed fixed point, fully pipelined
// pipeline: front end, a chain of one-bit division stages (one per quotient bit) and an
// output register; every op takes the same path
// throughput: one word per cycle; the whole pipeline holds while the output is stalled
// reset: synchronous, clears the valid bits only
// depends on cau_pkg, cau_front, cau_div_step, cau_back
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = cau_pkg::DataWidthDef,
  parameter int FRAC_BITS  = cau_pkg::FracBitsDef
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  // a_re, a_im, b_re, b_im
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]            s_tdata,
  // op
  input  logic [1:0]                                   s_tuser,
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  // res_re, res_im
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]            m_tdata,
  // status
  output logic [1:0]                                   m_tuser
);
  import cau_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int W2   = 2 * W;
  localparam int NW   = 2 * W + 1 + FRAC_BITS;
  localparam int OUTW = ((2 * W + 7) / 8) * 8;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  ctl_t          ctl [NW+1];
  logic [W2-1:0] den [NW+1];
  logic [NW-1:0] nq_re [NW+1];
  logic [NW-1:0] nq_im [NW+1];
  logic [W2-1:0] rem_re [NW+1];
  logic [W2-1:0] rem_im [NW+1];
  logic [W2:0]   den_guard;

  cau_front #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid),
    .op(op_t'(s_tuser)),
    .a_re(s_tdata[W-1:0]),
    .a_im(s_tdata[2*W-1:W]),
    .b_re(s_tdata[3*W-1:2*W]),
    .b_im(s_tdata[4*W-1:3*W]),
    .ctl(ctl[0]),
    .den_unused_guard(den_guard),
    .mag_re(nq_re[0]),
    .mag_im(nq_im[0]),
    .den(den[0])
  );

  assign rem_re[0] = '0;
  assign rem_im[0] = '0;

  for (genvar k = 0; k < NW; k++) begin : g_div
    cau_div_step #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_step (
      .clk(clk), .rst(rst), .en(en),
      .ctl_in(ctl[k]), .den_in(den[k]),
      .nq_re_in(nq_re[k]), .nq_im_in(nq_im[k]),
      .rem_re_in(rem_re[k]), .rem_im_in(rem_im[k]),
      .ctl_out(ctl[k+1]), .den_out(den[k+1]),
      .nq_re_out(nq_re[k+1]), .nq_im_out(nq_im[k+1]),
      .rem_re_out(rem_re[k+1]), .rem_im_out(rem_im[k+1])
    );
  end

  logic [W-1:0] res_re, res_im;
  status_t      status;

  // the top bit of the guard is always zero; fold it into the last stage's control
  ctl_t ctl_last;
  always_comb begin
    ctl_last       = ctl[NW];
    ctl_last.valid = ctl[NW].valid && !den_guard[W2];
  end

  cau_back #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .en(en),
    .ctl(ctl_last),
    .mag_re(nq_re[NW]),
    .mag_im(nq_im[NW]),
    .out_valid(m_tvalid),
    .res_re(res_re),
    .res_im(res_im),
    .status(status)
  );

  assign m_tdata = OUTW'({res_im, res_re});
  assign m_tuser = status;

endmodule

[rtl/cau_checker.sv]
// port-level checks for the complex arithmetic unit, bound to the top level
// depends on cau_pkg
module cau_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tready,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [((2*DATA_WIDTH+7)/8)*8-1:0]    m_tdata,
  input logic [1:0]                           m_tuser
);
  import cau_pkg::*;

  localparam int W = DATA_WIDTH;

  logic [W-1:0] re, im;
  assign re = m_tdata[W-1:0];
  assign im = m_tdata[2*W-1:W];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_DZ) |-> (re == '0) && (im == '0))
    else $error("divide by zero word is not zero");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_SAT) |->
      (re == {1'b0, {(W-1){1'b1}}}) || (re == {1'b1, {(W-1){1'b0}}}) ||
      (im == {1'b0, {(W-1){1'b1}}}) || (im == {1'b1, {(W-1){1'b0}}}))
    else $error("saturated word has no part at a rail");

endmodule

bind complex_arithmetic_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (.*);
